// ===== design/scp_pkg.sv =====
// shared types, constants and register codes for the stream pattern censor
package scp_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int DATA_W          = 8;
   localparam int REG_W           = 64;
   localparam int LEN_W           = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int PAT_BYTES       = 16;
   localparam int PAT_IDX_W       = 4;

   typedef logic [DATA_W-1:0] byte_type;

   localparam byte_type STAR_BYTE    = 8'd42;
   localparam byte_type NEWLINE_BYTE = 8'd10;
   localparam byte_type NUL_BYTE     = 8'd0;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

   typedef struct packed {
      logic [REG_W-1:0] pat_low;
      logic [REG_W-1:0] pat_high;
      logic [LEN_W-1:0] pat_len;
   } cfg_type;

endpackage

// ===== design/stream_pattern_censor_unit.sv =====
// Stream pattern censor: replaces each leftmost, non-overlapping occurrence of a
// configured byte pattern (1 to MAX_PATTERN bytes) with asterisks, delaying the text
// by a window as long as the pattern; a newline, a zero byte or end_of_stream flushes
// the window, so matches never cross a line. A zero pattern length answers each byte
// with one result flagged on rsp_no_pattern. An accepted byte waits in the input register
// until the result register can load; window compare and run planning are combinational,
// so the block takes one byte per cycle while each byte causes at most one result and
// rsp_stall is low. A byte that causes several results (a match, a flush) holds the
// result register until its last result is transferred, since results leave it one per transfer,
// and the input stalls meanwhile. Configuration is written via csr_index/csr_wdata: 0
// pattern bytes 0..7, 1 pattern bytes 8..15, 2 pattern length; other indexes are ignored.
module stream_pattern_censor_unit #(
   parameter int MAX_PATTERN = scp_pkg::MAX_PATTERN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  scp_pkg::byte_type              req_in_byte,
   input  logic                           req_end_of_stream,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output scp_pkg::byte_type              rsp_out_byte,
   output logic                           rsp_last_of_run,
   output logic                           rsp_no_pattern,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scp_pkg::REG_W-1:0]      csr_wdata
);
   import scp_pkg::*;

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   cfg_type                cfg;
   logic                   in_vld_ff;
   logic                   in_vld_in;
   byte_type               in_byte_ff;
   logic                   in_eos_ff;
   logic                   can_load;
   logic                   step_load;
   byte_type               plan_buf [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] plan_mask;
   logic [CNT_W-1:0]       plan_cnt;
   logic [IDX_W-1:0]       plan_start;
   logic                   plan_inv;

   scp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register
   assign req_stall = in_vld_ff && !can_load;
   assign step_load = in_vld_ff && can_load;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   scp_step #(
      .MAX_PATTERN (MAX_PATTERN),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .load       (step_load),
      .in_byte    (in_byte_ff),
      .in_eos     (in_eos_ff),
      .cfg        (cfg),
      .plan_buf   (plan_buf),
      .plan_mask  (plan_mask),
      .plan_cnt   (plan_cnt),
      .plan_start (plan_start),
      .plan_inv   (plan_inv)
   );

   scp_emit #(
      .MAX_PATTERN (MAX_PATTERN),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (step_load),
      .plan_buf        (plan_buf),
      .plan_mask       (plan_mask),
      .plan_cnt        (plan_cnt),
      .plan_start      (plan_start),
      .plan_inv        (plan_inv),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_no_pattern  (rsp_no_pattern)
   );

`ifndef SYNTHESIS
   // a no-pattern result is always a run of one
   a_inv_single : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_pattern) |-> rsp_last_of_run)
      else $error("no-pattern result not marked last");

   // a pending byte waits while a run still has more than one result to go
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && rsp_valid && !rsp_last_of_run) |-> req_stall)
      else $error("input accepted in the middle of a run");

   // a run does not end before its last result is transferred
   a_run_cont : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run) |=> rsp_valid)
      else $error("run ended early");
`endif

endmodule

// ===== design/scp_csr.sv =====
// configuration registers: pattern bytes and pattern length
module scp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scp_pkg::REG_W-1:0]      csr_wdata,
   output scp_pkg::cfg_type               cfg
);
   import scp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PATTERN_LOW:  cfg_in.pat_low  = csr_wdata;
            REG_PATTERN_HIGH: cfg_in.pat_high = csr_wdata;
            REG_PATTERN_LEN:  cfg_in.pat_len  = csr_wdata[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/scp_step.sv =====
// delay window state and the single-pass match and run planning logic
module scp_step #(
   parameter int MAX_PATTERN = scp_pkg::MAX_PATTERN_DEF,
   parameter int CNT_W       = $clog2(MAX_PATTERN + 1),
   parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  scp_pkg::byte_type         in_byte,
   input  logic                      in_eos,
   input  scp_pkg::cfg_type          cfg,
   output scp_pkg::byte_type         plan_buf [MAX_PATTERN],
   output logic [MAX_PATTERN-1:0]    plan_mask,
   output logic [CNT_W-1:0]          plan_cnt,
   output logic [IDX_W-1:0]          plan_start,
   output logic                      plan_inv
);
   import scp_pkg::*;

   // window held newest first: win_ff[0] is the most recent byte
   byte_type         win_ff [MAX_PATTERN];
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;

   byte_type         pat_arr [PAT_BYTES];
   byte_type         cand    [MAX_PATTERN];
   logic [LEN_W-1:0] len_sat;
   logic [CNT_W-1:0] len_cnt;
   logic [CNT_W-1:0] fill_one;
   logic             brk;
   logic             full;
   logic             all_eq;
   logic             match;
   logic [LEN_W-1:0] pidx;

   // pattern bytes as an array, byte 0 in the low bits of the low register
   always_comb begin
      for (int j = 0; j < PAT_BYTES / 2; j++) begin
         pat_arr[j]                 = cfg.pat_low[DATA_W*j +: DATA_W];
         pat_arr[j + PAT_BYTES / 2] = cfg.pat_high[DATA_W*j +: DATA_W];
      end
   end

   // candidate window: incoming byte in front of the stored bytes
   always_comb begin
      cand[0] = in_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         cand[k] = win_ff[k-1];
      end
   end

   // length saturation and line break detect
   always_comb begin
      len_sat  = (cfg.pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : cfg.pat_len;
      len_cnt  = CNT_W'(len_sat);
      fill_one = fill_ff + CNT_W'(1);
      brk      = (in_byte == NEWLINE_BYTE) || (in_byte == NUL_BYTE);
      full     = fill_one >= len_cnt;
   end

   // parallel compare of the newest len bytes against the pattern
   always_comb begin
      all_eq = 1'b1;
      pidx   = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pidx = len_sat - LEN_W'(k) - LEN_W'(1);
         if ((LEN_W'(k) < len_sat) && (cand[k] != pat_arr[pidx[PAT_IDX_W-1:0]])) begin
            all_eq = 1'b0;
         end
      end
      match = full && all_eq && !brk;
   end

   // result run: count, star positions, next fill
   always_comb begin
      plan_inv   = (len_sat == '0);
      plan_start = IDX_W'(fill_ff);
      for (int k = 0; k < MAX_PATTERN; k++) begin
         plan_mask[k] = match && (LEN_W'(k) < len_sat);
      end
      if (plan_inv) begin
         plan_cnt = CNT_W'(1);
      end else if (brk || (full && (match || in_eos))) begin
         plan_cnt = fill_one;
      end else if (full) begin
         plan_cnt = fill_one - len_cnt + CNT_W'(1);
      end else if (in_eos) begin
         plan_cnt = fill_one;
      end else begin
         plan_cnt = '0;
      end
      if (plan_inv) begin
         fill_in = fill_ff;
      end else if (brk) begin
         fill_in = '0;
      end else begin
         fill_in = fill_one - plan_cnt;
      end
   end

   assign plan_buf = cand;

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (load) begin
         fill_ff <= fill_in;
      end
   end

   // window bytes, meaningful only below the fill count
   always_ff @(posedge clock) begin
      if (load && !plan_inv) begin
         win_ff <= cand;
      end
   end

endmodule

// ===== design/scp_emit.sv =====
// result register: holds one run and hands out one result per transfer
module scp_emit #(
   parameter int MAX_PATTERN = scp_pkg::MAX_PATTERN_DEF,
   parameter int CNT_W       = $clog2(MAX_PATTERN + 1),
   parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  scp_pkg::byte_type         plan_buf [MAX_PATTERN],
   input  logic [MAX_PATTERN-1:0]    plan_mask,
   input  logic [CNT_W-1:0]          plan_cnt,
   input  logic [IDX_W-1:0]          plan_start,
   input  logic                      plan_inv,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output scp_pkg::byte_type         rsp_out_byte,
   output logic                      rsp_last_of_run,
   output logic                      rsp_no_pattern
);
   import scp_pkg::*;

   logic                   run_vld_ff;
   logic                   run_vld_in;
   byte_type               buf_ff  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] mask_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       idx_in;
   logic [CNT_W-1:0]       rem_ff;
   logic [CNT_W-1:0]       rem_in;
   logic                   inv_ff;
   logic                   last;
   logic                   xfer;

   assign last     = (rem_ff == CNT_W'(1));
   assign xfer     = run_vld_ff && !rsp_stall;
   assign can_load = !run_vld_ff || (xfer && last);

   // run control: load a new run or step to the next newer byte
   always_comb begin
      run_vld_in = run_vld_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      if (load) begin
         run_vld_in = (plan_cnt != '0);
         idx_in     = plan_start;
         rem_in     = plan_cnt;
      end else if (xfer) begin
         if (last) begin
            run_vld_in = 1'b0;
         end else begin
            idx_in = idx_ff - IDX_W'(1);
            rem_in = rem_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_vld_ff <= 1'b0;
      end else begin
         run_vld_ff <= run_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rem_ff <= rem_in;
   end

   // run payload
   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff  <= plan_buf;
         mask_ff <= plan_mask;
         inv_ff  <= plan_inv;
      end
   end

   // result fields
   always_comb begin
      rsp_valid       = run_vld_ff;
      rsp_last_of_run = last;
      rsp_no_pattern  = inv_ff;
      if (inv_ff) begin
         rsp_out_byte = NUL_BYTE;
      end else if (mask_ff[idx_ff]) begin
         rsp_out_byte = STAR_BYTE;
      end else begin
         rsp_out_byte = buf_ff[idx_ff];
      end
   end

endmodule
